### rtl/core/hbcz_pkg.sv
// ----------------------------------------------------------------------------
// hbcz_pkg
// Shared types, constants and helpers of the band column zone detector.
// ----------------------------------------------------------------------------
package hbcz_pkg;

  // image geometry
  localparam int IMAGE_WIDTH = 320;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 9;
  localparam int IDX_W       = $clog2(IMAGE_WIDTH);
  localparam int CNT_W       = 10;
  localparam int HIT_W       = 8;
  localparam int NUM_SEG     = 5;
  localparam int SEG_W       = 3;

  // band corner and colour register widths
  localparam int HSL_W       = 8;
  localparam int BAND_W      = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  // division of d*col by IMAGE_WIDTH: shift by 6, then times ceil(2^16/5) >> 16
  // exact for the shifted value below 16384
  localparam int DIV_SHIFT   = 6;
  localparam int DIV_MUL_W   = 15;
  localparam int DIV_POST    = 16;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 15'd13108;

  // derived datapath widths
  localparam int PROD_W  = BAND_W + IDX_W;
  localparam int SHR_W   = PROD_W - DIV_SHIFT;
  localparam int RECIP_W = SHR_W + DIV_MUL_W;
  localparam int EDGE_W  = BAND_W + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LUM_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEFT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_RIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOT_LEFT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BOT_RIGHT   = 3'd7;

  // register reset values
  localparam logic [HSL_W-1:0]  RST_HUE_LOW  = 8'd220;
  localparam logic [HSL_W-1:0]  RST_HUE_HIGH = 8'd255;
  localparam logic [HSL_W-1:0]  RST_SAT_LOW  = 8'd75;
  localparam logic [HSL_W-1:0]  RST_LUM_LOW  = 8'd85;
  localparam logic [BAND_W-1:0] RST_TOP      = 9'd160;
  localparam logic [BAND_W-1:0] RST_BOT      = 9'd80;

  // column segments, inclusive bounds
  localparam logic [IDX_W-1:0] SEG_LO [NUM_SEG] = '{9'd0, 9'd151, 9'd201, 9'd301, 9'd311};
  localparam logic [IDX_W-1:0] SEG_HI [NUM_SEG] = '{9'd150, 9'd200, 9'd300, 9'd310, 9'd319};

  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  // stage after input register: band products
  typedef struct packed {
    logic [IDX_W-1:0]  col;
    logic              in_range;
    logic [ROW_W-1:0]  row;
    logic              match;
    logic              fend;
    logic [PROD_W-1:0] prod_top;
    logic [PROD_W-1:0] prod_bot;
  } p1_t;

  // stage after reciprocal multiply
  typedef struct packed {
    logic [IDX_W-1:0]   col;
    logic               in_range;
    logic [ROW_W-1:0]   row;
    logic               match;
    logic               fend;
    logic [RECIP_W-1:0] q_top;
    logic [RECIP_W-1:0] q_bot;
  } p2_t;

  // count update stage
  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic             in_band;
    logic             first;
    logic             last;
    logic [CNT_W-1:0] height;
    logic             match;
    logic             seg_vld;
    logic [SEG_W-1:0] seg;
    logic             fend;
  } p3_t;

  typedef struct packed {
    logic             vld;
    logic [SEG_W-1:0] idx;
  } seg_sel_t;

  // segment lookup of an in-range column
  function automatic seg_sel_t segment_of(input logic [IDX_W-1:0] col);
    seg_sel_t r;
    r = '0;
    for (int s = NUM_SEG - 1; s >= 0; s--) begin
      if (col >= SEG_LO[s] && col <= SEG_HI[s]) begin
        r.vld = 1'b1;
        r.idx = SEG_W'(s);
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/hbcz_ram.sv
// ----------------------------------------------------------------------------
// hbcz_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hbcz_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/hsl_band_column_zone_detector_top.sv
// ----------------------------------------------------------------------------
// hsl_band_column_zone_detector_top
// Counts colour matches inside a sloped row band per column and reports the
// first column segment with enough matching columns at the end of a frame.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one transaction per
// pixel; s_axis_tlast marks the last pixel of a frame. One result
// transaction leaves on m_axis for each frame end: the zone index in tdata
// and the found flag in tuser.
// Throughput is one pixel per clock while the pipeline is not held. The
// per-column match counts sit in a 320 x 10 RAM with one read and one write
// port; each pixel reads its column's count as it enters the count stage
// and writes it back as it leaves that stage, with a one-deep forward
// covering a write that lands while the next read is in flight.
// m_axis_tvalid rises once the accepted frame-end pixel has passed the
// reciprocal multiply, the count stage and the output register.
// A pending result does not block input; only a second frame end reaching
// the count stage while the previous result is still unread holds the
// pipeline, and s_axis_tready drops for those cycles.
// Reset loads the default colour window and band corners and clears the
// segment counters; the count RAM is not cleared, a column's count is
// written at its first band row. Configuration writes go through cfg_* and
// take effect at once; write them only while no pixel is in flight.
// ----------------------------------------------------------------------------
module hsl_band_column_zone_detector_top
  import hbcz_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // column, row, hue, saturation, luminance
  input  logic                  s_axis_tlast,  // frame_end
  // result output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // zone
  output logic                  m_axis_tuser,  // zone_found
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // configuration registers
  logic [HSL_W-1:0]  hue_low_q, hue_high_q, sat_low_q, lum_low_q;
  logic [BAND_W-1:0] top_left_q, top_right_q, bot_left_q, bot_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q   <= RST_HUE_LOW;
      hue_high_q  <= RST_HUE_HIGH;
      sat_low_q   <= RST_SAT_LOW;
      lum_low_q   <= RST_LUM_LOW;
      top_left_q  <= RST_TOP;
      top_right_q <= RST_TOP;
      bot_left_q  <= RST_BOT;
      bot_right_q <= RST_BOT;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_HUE_LOW:   hue_low_q   <= cfg_wdata_i[HSL_W-1:0];
        CFG_HUE_HIGH:  hue_high_q  <= cfg_wdata_i[HSL_W-1:0];
        CFG_SAT_LOW:   sat_low_q   <= cfg_wdata_i[HSL_W-1:0];
        CFG_LUM_LOW:   lum_low_q   <= cfg_wdata_i[HSL_W-1:0];
        CFG_TOP_LEFT:  top_left_q  <= cfg_wdata_i[BAND_W-1:0];
        CFG_TOP_RIGHT: top_right_q <= cfg_wdata_i[BAND_W-1:0];
        CFG_BOT_LEFT:  bot_left_q  <= cfg_wdata_i[BAND_W-1:0];
        CFG_BOT_RIGHT: bot_right_q <= cfg_wdata_i[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic stall;
  logic adv;
  logic p1_vld_q, p2_vld_q, p3_vld_q;
  p1_t  p1_d, p1_q;
  p2_t  p2_d, p2_q;
  p3_t  p3_d, p3_q;

  assign adv           = !stall;
  assign s_axis_tready = adv;

  // input unpack
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [HSL_W-1:0] in_hue, in_sat, in_lum;

  assign in_col = s_axis_tdata[9:0];
  assign in_row = s_axis_tdata[18:10];
  assign in_hue = s_axis_tdata[26:19];
  assign in_sat = s_axis_tdata[34:27];
  assign in_lum = s_axis_tdata[42:35];

  // band slopes from the corner registers
  logic [BAND_W-1:0] d_top, d_bot;

  assign d_top = (top_left_q >= top_right_q) ? top_left_q - top_right_q
                                             : top_right_q - top_left_q;
  assign d_bot = (bot_left_q >= bot_right_q) ? bot_left_q - bot_right_q
                                             : bot_right_q - bot_left_q;

  // stage 1: colour window and slope times column
  always_comb begin
    p1_d          = '0;
    p1_d.col      = in_col[IDX_W-1:0];
    p1_d.in_range = ({1'b0, in_col} < (COL_W + 1)'(IMAGE_WIDTH));
    p1_d.row      = in_row;
    p1_d.match    = (in_hue >= hue_low_q) && (in_hue <= hue_high_q) &&
                    (in_sat >= sat_low_q) && (in_lum >= lum_low_q);
    p1_d.fend     = s_axis_tlast;
    p1_d.prod_top = PROD_W'(d_top) * PROD_W'(in_col[IDX_W-1:0]);
    p1_d.prod_bot = PROD_W'(d_bot) * PROD_W'(in_col[IDX_W-1:0]);
  end

  // stage 2: divide by the image width through a reciprocal multiply
  always_comb begin
    p2_d          = '0;
    p2_d.col      = p1_q.col;
    p2_d.in_range = p1_q.in_range;
    p2_d.row      = p1_q.row;
    p2_d.match    = p1_q.match;
    p2_d.fend     = p1_q.fend;
    p2_d.q_top    = RECIP_W'(p1_q.prod_top[PROD_W-1:DIV_SHIFT]) * RECIP_W'(DIV_MUL);
    p2_d.q_bot    = RECIP_W'(p1_q.prod_bot[PROD_W-1:DIV_SHIFT]) * RECIP_W'(DIV_MUL);
  end

  // stage 3: band edges, membership and segment
  logic signed [EDGE_W-1:0] upper, lower, row_s, first_row, height_s;
  seg_sel_t                 seg_sel;

  always_comb begin
    upper     = $signed({2'b00, top_left_q}) -
                $signed({2'b00, p2_q.q_top[DIV_POST +: BAND_W]});
    lower     = $signed({2'b00, bot_left_q}) -
                $signed({2'b00, p2_q.q_bot[DIV_POST +: BAND_W]});
    row_s     = $signed({2'b00, p2_q.row});
    first_row = (lower < 0) ? '0 : lower;
    height_s  = upper - lower;
    seg_sel   = segment_of(p2_q.col);

    p3_d         = '0;
    p3_d.col     = p2_q.col;
    p3_d.in_band = p2_q.in_range && (row_s >= lower) && (row_s < upper);
    p3_d.first   = (row_s == first_row);
    p3_d.last    = (row_s == upper - EDGE_W'(1));
    p3_d.height  = height_s[CNT_W-1:0];
    p3_d.match   = p2_q.match;
    p3_d.seg_vld = seg_sel.vld;
    p3_d.seg     = seg_sel.idx;
    p3_d.fend    = p2_q.fend;
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q <= s_axis_tvalid;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
  end

  // column count memory, read as the item enters stage 3
  logic             ram_we;
  logic [CNT_W-1:0] ram_rdata;
  logic [CNT_W-1:0] cnt;

  hbcz_ram #(
    .WIDTH (CNT_W),
    .DEPTH (IMAGE_WIDTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (p3_q.col),
    .wdata_i (cnt),
    .re_i    (adv),
    .raddr_i (p2_q.col),
    .rdata_o (ram_rdata)
  );

  // forward the write that landed alongside this item's read
  logic             wr_vld_q;
  logic [IDX_W-1:0] wr_addr_q;
  logic [CNT_W-1:0] wr_data_q;
  logic [CNT_W-1:0] cnt_old;

  assign cnt_old = (wr_vld_q && (wr_addr_q == p3_q.col)) ? wr_data_q : ram_rdata;
  assign cnt     = p3_q.first ? CNT_W'(p3_q.match) : cnt_old + CNT_W'(p3_q.match);
  assign ram_we  = adv && p3_vld_q && p3_q.in_band;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_vld_q <= 1'b0;
    end else if (adv) begin
      wr_vld_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr_addr_q <= p3_q.col;
      wr_data_q <= cnt;
    end
  end

  // column flag and segment hit update
  logic             col_flag;
  logic [HIT_W-1:0] hits_q [NUM_SEG];
  logic [HIT_W-1:0] hits_d [NUM_SEG];
  logic             frame_done;

  assign col_flag   = p3_vld_q && p3_q.in_band && p3_q.last && p3_q.seg_vld &&
                      ({cnt, 1'b0} > {1'b0, p3_q.height});
  assign frame_done = adv && p3_vld_q && p3_q.fend;

  always_comb begin
    for (int s = 0; s < NUM_SEG; s++) begin
      hits_d[s] = hits_q[s];
      if (col_flag && (p3_q.seg == SEG_W'(s)) && (hits_q[s] != HIT_MAX)) begin
        hits_d[s] = hits_q[s] + HIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SEG; s++) begin
        hits_q[s] <= '0;
      end
    end else if (frame_done) begin
      for (int s = 0; s < NUM_SEG; s++) begin
        hits_q[s] <= '0;
      end
    end else if (adv) begin
      for (int s = 0; s < NUM_SEG; s++) begin
        hits_q[s] <= hits_d[s];
      end
    end
  end

  // first segment above half its span
  seg_sel_t zone_sel;

  always_comb begin
    zone_sel = '0;
    for (int s = NUM_SEG - 1; s >= 0; s--) begin
      if ({hits_d[s], 1'b0} > (HIT_W + 1)'(SEG_HI[s] - SEG_LO[s])) begin
        zone_sel.vld = 1'b1;
        zone_sel.idx = SEG_W'(s);
      end
    end
  end

  // result register
  logic             out_vld_q;
  logic             out_found_q;
  logic [SEG_W-1:0] out_zone_q;

  assign stall = p3_vld_q && p3_q.fend && out_vld_q && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (frame_done) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      out_found_q <= zone_sel.vld;
      out_zone_q  <= zone_sel.vld ? zone_sel.idx : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(8 - SEG_W)'(0), out_zone_q};
  assign m_axis_tuser  = out_found_q;

  // segment counters are clear after a frame end
  a_hits_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> (hits_q[0] == '0) && (hits_q[1] == '0) && (hits_q[2] == '0) &&
                   (hits_q[3] == '0) && (hits_q[4] == '0))
    else $error("segment counters not cleared after frame end");

  // a new result only comes from a frame end leaving the count stage
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(frame_done))
    else $error("result raised without a frame end");

  // a held pipeline keeps the count stage and writes nothing
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> !ram_we && !s_axis_tready)
    else $error("memory written or input taken during stall");

  // no zone index without the found flag
  a_zone_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("zone index set while no zone found");

endmodule

### test/hsl_band_column_zone_detector_top_tb.sv
// ----------------------------------------------------------------------------
// hsl_band_column_zone_detector_top_tb
// Pixel streams with small, often sloped row bands, frame ends and register
// sweeps; each zone result is checked against a cycle-free model of the
// per-column match counts and the segment hit counters.
// ----------------------------------------------------------------------------
module hsl_band_column_zone_detector_top_tb
  import hbcz_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT   = 500000;
  localparam int DRAIN_WAIT  = 8;
  localparam int FRAME_CAP   = 320;
  localparam int ITEM_TARGET = 1150;
  localparam int CALM_FROM   = 950;
  localparam int TAIL_PIXELS = 40;

  // column segments, inclusive bounds
  localparam int SEG_START [NUM_SEG] = '{0, 151, 201, 301, 311};
  localparam int SEG_STOP  [NUM_SEG] = '{150, 200, 300, 310, 319};

  typedef struct {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [HSL_W-1:0] hue;
    logic [HSL_W-1:0] sat;
    logic [HSL_W-1:0] lum;
    logic             fend;
  } pixel_t;

  typedef struct {
    logic             found;
    logic [SEG_W-1:0] zone;
  } zone_rec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // register copy, shared by the stimulus generator and the predictor
  int hue_lo, hue_hi, sat_min, lum_min, top_l, top_r, bot_l, bot_r;

  // predictor state
  int col_matches [IMAGE_WIDTH];
  int seg_hits [NUM_SEG];
  zone_rec_t zone_due [$];

  // generator state: columns whose count has been written since reset
  bit col_written [IMAGE_WIDTH];
  pixel_t pending_px [$];
  pixel_t drive_px;

  bit pix_taken;
  bit calm;
  int src_pct, out_pct, src_hold, out_hold;
  int n_items, n_frames, n_found, n_settings, n_errors;

  hsl_band_column_zone_detector_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // sloped band edge at a column, floor division of the corner difference
  function automatic int band_row(int left, int right, int col);
    int d;
    d = (left > right) ? left - right : right - left;
    return left - (d * col) / IMAGE_WIDTH;
  endfunction

  function automatic bit color_hit(int h, int s, int l);
    return h >= hue_lo && h <= hue_hi && s >= sat_min && l >= lum_min;
  endfunction

  function automatic int column_segment(int col);
    for (int s = 0; s < NUM_SEG; s++)
      if (col >= SEG_START[s] && col <= SEG_STOP[s]) return s;
    return -1;
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] zone check failed: %s", $realtime, what);
    n_errors++;
  endtask

  // predictor: one accepted pixel
  task automatic track_pixel(pixel_t p);
    int col, row, up, lo, first_row, cnt, sg;
    bit hit;
    zone_rec_t z;
    col = p.column;
    row = p.row;
    if (col < IMAGE_WIDTH) begin
      up = band_row(top_l, top_r, col);
      lo = band_row(bot_l, bot_r, col);
      if (row >= lo && row < up) begin
        first_row = (lo < 0) ? 0 : lo;
        hit = color_hit(p.hue, p.sat, p.lum);
        cnt = (row == first_row) ? hit : col_matches[col] + hit;
        cnt = cnt % 1024;
        col_matches[col] = cnt;
        sg = column_segment(col);
        // last band row closes the column; a set flag bumps its segment
        if (row == up - 1 && 2 * cnt > up - lo && sg >= 0 && seg_hits[sg] < HIT_MAX)
          seg_hits[sg]++;
      end
    end
    if (p.fend) begin
      z.found = 1'b0;
      z.zone  = '0;
      for (int s = 0; s < NUM_SEG; s++) begin
        if (!z.found && 2 * seg_hits[s] > SEG_STOP[s] - SEG_START[s]) begin
          z.found = 1'b1;
          z.zone  = SEG_W'(s);
        end
      end
      zone_due.push_back(z);
      foreach (seg_hits[s]) seg_hits[s] = 0;
    end
  endtask

  task automatic take_result();
    zone_rec_t want;
    if (zone_due.size() == 0) begin
      flag_mismatch($sformatf("result zone=%0d found=%0b with none expected",
                              m_axis_tdata, m_axis_tuser));
      return;
    end
    want = zone_due.pop_front();
    if (m_axis_tuser !== want.found)
      flag_mismatch($sformatf("found %0b, expected %0b", m_axis_tuser, want.found));
    if (m_axis_tdata !== {5'b0, want.zone})
      flag_mismatch($sformatf("zone %0d, expected %0d", m_axis_tdata, want.zone));
    if (want.found) n_found++;
  endtask

  // pixel driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || pix_taken) begin
      pix_taken = 1'b0;
      if (src_hold > 0) begin
        src_hold--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_px.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(99, 0) < src_pct) begin
        src_hold = $urandom_range(16, 0);
        s_axis_tvalid <= 1'b0;
      end else begin
        drive_px = pending_px.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, drive_px.lum, drive_px.sat, drive_px.hue,
                          drive_px.row, drive_px.column};
        s_axis_tlast  <= drive_px.fend;
      end
    end
  end

  // result sink with stall bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(99, 0) < out_pct) begin
      out_hold = $urandom_range(16, 0);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) take_result();
      if (s_axis_tvalid && s_axis_tready) begin
        pix_taken = 1'b1;
        track_pixel(drive_px);
      end
    end
  end

  // register write, only while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_HUE_LOW:   hue_lo  = val & 8'hFF;
      CFG_HUE_HIGH:  hue_hi  = val & 8'hFF;
      CFG_SAT_LOW:   sat_min = val & 8'hFF;
      CFG_LUM_LOW:   lum_min = val & 8'hFF;
      CFG_TOP_LEFT:  top_l   = val & 9'h1FF;
      CFG_TOP_RIGHT: top_r   = val & 9'h1FF;
      CFG_BOT_LEFT:  bot_l   = val & 9'h1FF;
      CFG_BOT_RIGHT: bot_r   = val & 9'h1FF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int hl, int hh, int sl, int ll, int tl, int tr, int bl, int br);
    write_reg(CFG_HUE_LOW, hl);
    write_reg(CFG_HUE_HIGH, hh);
    write_reg(CFG_SAT_LOW, sl);
    write_reg(CFG_LUM_LOW, ll);
    write_reg(CFG_TOP_LEFT, tl);
    write_reg(CFG_TOP_RIGHT, tr);
    write_reg(CFG_BOT_LEFT, bl);
    write_reg(CFG_BOT_RIGHT, br);
    n_settings++;
  endtask

  // wait until every pixel is taken and every result is in
  task automatic settle();
    do @(posedge clk_i);
    while (pending_px.size() != 0 || s_axis_tvalid || zone_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // queue one pixel; a later band row of a never written column becomes its
  // first band row so that no undefined count is read
  task automatic push_px(int col, int row, int h, int s, int l, bit fend);
    int up, lo, first_row, r;
    pixel_t p;
    r = row;
    if (col < IMAGE_WIDTH) begin
      up = band_row(top_l, top_r, col);
      lo = band_row(bot_l, bot_r, col);
      if (r >= lo && r < up) begin
        first_row = (lo < 0) ? 0 : lo;
        if (r != first_row && !col_written[col]) r = first_row;
        col_written[col] = 1'b1;
      end
    end
    p.column = COL_W'(col);
    p.row    = ROW_W'(r);
    p.hue    = HSL_W'(h);
    p.sat    = HSL_W'(s);
    p.lum    = HSL_W'(l);
    p.fend   = fend;
    pending_px.push_back(p);
    n_items++;
  endtask

  task automatic pick_color(bit want, output int h, output int s, output int l);
    if (want && hue_lo <= hue_hi) begin
      h = $urandom_range(hue_hi, hue_lo);
      s = $urandom_range(255, sat_min);
      l = $urandom_range(255, lum_min);
    end else begin
      h = $urandom_range(255, 0);
      s = $urandom_range(255, 0);
      l = $urandom_range(255, 0);
    end
  endtask

  task automatic noise_px(bit fend);
    int h, s, l;
    pick_color($urandom_range(1, 0), h, s, l);
    push_px($urandom_range(1023, 0), $urandom_range(511, 0), h, s, l, fend);
  endtask

  // one raster frame over columns c0..c1, band pixels with some dropped, plus noise pixels
  task automatic band_frame(int c0, int c1, int pct);
    int up, lo, total, r_lo, r_hi, h, s, l, base;
    base = pending_px.size();
    do begin
      total = 0;
      r_lo  = 512;
      r_hi  = -1;
      for (int c = c0; c <= c1; c++) begin
        up = band_row(top_l, top_r, c);
        lo = band_row(bot_l, bot_r, c);
        if (lo < 0) lo = 0;
        if (up > lo) begin
          total += up - lo;
          if (lo < r_lo) r_lo = lo;
          if (up - 1 > r_hi) r_hi = up - 1;
        end
      end
      if (total > FRAME_CAP) c1 = c0 + (c1 - c0) / 2;
    end while (total > FRAME_CAP && c1 > c0);
    if (total > FRAME_CAP) r_hi = -1;
    for (int r = r_lo; r <= r_hi; r++) begin
      for (int c = c0; c <= c1; c++) begin
        up = band_row(top_l, top_r, c);
        lo = band_row(bot_l, bot_r, c);
        if (r >= lo && r < up && $urandom_range(99, 0) >= 3) begin
          pick_color($urandom_range(99, 0) < pct, h, s, l);
          push_px(c, r, h, s, l, 1'b0);
        end
      end
      if ($urandom_range(99, 0) < 10) noise_px(1'b0);
    end
    if (pending_px.size() > base && $urandom_range(1, 0)) pending_px[$].fend = 1'b1;
    else noise_px(1'b1);
    n_frames++;
  endtask

  function automatic int pick_floor();
    case ($urandom_range(9, 0))
      0: return 0;
      1: return 255;
      default: return $urandom_range(150, 0);
    endcase
  endfunction

  function automatic int pick_corner();
    case ($urandom_range(3, 0))
      0: return 0;
      1: return 511;
      default: return $urandom_range(511, 0);
    endcase
  endfunction

  // random register setting; bit 8 of the 8-bit registers is junk
  task automatic random_config();
    int hl, hh, tl, tr, bl, br;
    case ($urandom_range(9, 0))
      0: begin hl = 0; hh = 255; end
      1: begin hl = 255; hh = 0; end
      2: begin hl = $urandom_range(255, 1); hh = $urandom_range(hl - 1, 0); end
      default: begin hl = $urandom_range(200, 0); hh = $urandom_range(255, hl); end
    endcase
    if ($urandom_range(9, 0) < 7) begin
      // narrow band, flat or sloped
      bl = $urandom_range(505, 0);
      tl = bl + $urandom_range(3, 1);
      if ($urandom_range(9, 0) < 4) begin
        br = bl;
        tr = tl;
      end else begin
        br = $urandom_range(508, 0);
        tr = br + $urandom_range(3, 0);
      end
    end else begin
      tl = pick_corner();
      tr = pick_corner();
      bl = pick_corner();
      br = pick_corner();
    end
    set_config(hl | ($urandom_range(1, 0) << 8), hh | ($urandom_range(1, 0) << 8),
               pick_floor() | ($urandom_range(1, 0) << 8),
               pick_floor() | ($urandom_range(1, 0) << 8), tl, tr, bl, br);
  endtask

  task automatic random_frame();
    int sg, c0, c1, pct;
    case ($urandom_range(2, 0))
      0: pct = 95;
      1: pct = 70;
      default: pct = 40;
    endcase
    if ($urandom_range(4, 0) == 0) begin
      repeat ($urandom_range(30, 5)) noise_px(1'b0);
      noise_px(1'b1);
      n_frames++;
    end else if ($urandom_range(1, 0)) begin
      sg = $urandom_range(NUM_SEG - 1, 0);
      c0 = SEG_START[sg];
      c1 = SEG_STOP[sg];
      if ($urandom_range(9, 0) < 3) begin
        c0 = (c0 > 10) ? c0 - $urandom_range(10, 0) : 0;
        c1 = c1 + $urandom_range(20, 0);
        if (c1 > IMAGE_WIDTH - 1) c1 = IMAGE_WIDTH - 1;
      end
      band_frame(c0, c1, pct);
    end else begin
      c0 = $urandom_range(IMAGE_WIDTH - 1, 0);
      c1 = c0 + $urandom_range(30, 0);
      if (c1 > IMAGE_WIDTH - 1) c1 = IMAGE_WIDTH - 1;
      band_frame(c0, c1, pct);
    end
  endtask

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("hsl_band_column_zone_detector_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    int b, c, cnt, phase_no;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    hue_lo  = RST_HUE_LOW;
    hue_hi  = RST_HUE_HIGH;
    sat_min = RST_SAT_LOW;
    lum_min = RST_LUM_LOW;
    top_l   = RST_TOP;
    top_r   = RST_TOP;
    bot_l   = RST_BOT;
    bot_r   = RST_BOT;
    foreach (col_matches[i]) col_matches[i] = 0;
    foreach (col_written[i]) col_written[i] = 1'b0;
    foreach (seg_hits[i]) seg_hits[i] = 0;
    calm    = 1'b0;
    src_pct = 10;
    out_pct = 10;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: wide columns, field extremes, a frame end with no hits
    push_px(1023, 511, 255, 255, 255, 1'b0);
    push_px(320, 100, 230, 200, 200, 1'b0);
    push_px(0, 80, 255, 255, 255, 1'b0);
    push_px(0, 0, 0, 0, 0, 1'b0);
    push_px(0, 159, 220, 75, 85, 1'b0);
    push_px(319, 511, 0, 0, 0, 1'b1);
    settle();

    // one-row band, open window: five hits reach the rightmost segment
    set_config(0, 255, 0, 0, 1, 1, 0, 0);
    for (c = 311; c <= 315; c++) push_px(c, 0, 0, 0, 0, c == 315);
    settle();

    // empty hue window: no hits
    set_config(255, 0, 0, 0, 1, 1, 0, 0);
    for (c = 311; c <= 316; c++) push_px(c, 0, 255, 255, 255, c == 316);
    settle();

    // lower edge below zero at the right, two-row band at the left
    set_config(0, 255, 0, 0, 2, 2, 0, 511);
    push_px(300, 0, 255, 255, 255, 1'b0);
    push_px(300, 1, 255, 255, 255, 1'b0);
    push_px(0, 0, 128, 128, 128, 1'b0);
    push_px(0, 1, 127, 127, 127, 1'b1);
    settle();

    // random phases
    phase_no = 0;
    while (n_items < ITEM_TARGET) begin
      calm = (n_items >= CALM_FROM);
      case ($urandom_range(3, 0))
        0: src_pct = 0;
        1: src_pct = 5;
        2: src_pct = 25;
        default: src_pct = 50;
      endcase
      case ($urandom_range(3, 0))
        0: out_pct = 0;
        1: out_pct = 5;
        2: out_pct = 25;
        default: out_pct = 50;
      endcase
      if (phase_no == 3) begin
        // one column flagged over 255 times: the hit counter must saturate
        b = $urandom_range(510, 0);
        set_config(0, 255, 0, 0, b + 1, b + 1, b, b);
        c = $urandom_range(IMAGE_WIDTH - 1, 0);
        cnt = $urandom_range(262, 256);
        for (int i = 0; i < cnt; i++)
          push_px(c, b, $urandom_range(255, 0), $urandom_range(255, 0),
                  $urandom_range(255, 0), i == cnt - 1);
        n_frames++;
      end else begin
        random_config();
        repeat ($urandom_range(4, 1))
          if (n_items < ITEM_TARGET) random_frame();
      end
      settle();
      phase_no++;
    end

    // closing stretch with no idling on either side
    calm = 1'b1;
    repeat (TAIL_PIXELS) noise_px(1'b0);
    noise_px(1'b1);
    n_frames++;
    settle();

    repeat (16) @(posedge clk_i);
    while (zone_due.size() != 0) begin
      flag_mismatch("expected result never arrived");
      void'(zone_due.pop_front());
    end
    $display("covered %0d pixels in %0d frames under %0d register settings",
             n_items, n_frames, n_settings);
    $display("%0d frames reported a zone, %0d errors", n_found, n_errors);
    if (n_errors == 0) begin
      $display("hsl_band_column_zone_detector_top: match");
    end else begin
      $display("hsl_band_column_zone_detector_top: mismatch");
    end
    $finish;
  end

endmodule
